[sv/traffic_signal_mode_sequencer_core_macros.svh]
// Assertion macros for the traffic signal mode sequencer.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef TRAFFIC_SIGNAL_MODE_SEQUENCER_CORE_MACROS_SVH
`define TRAFFIC_SIGNAL_MODE_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge out of reset
`define TSMS_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("tsms: invariant violated");

// Antecedent implies consequent in the same cycle
`define TSMS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsms: implication violated");

// Antecedent implies consequent in the next cycle
`define TSMS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsms: next-cycle implication violated");

`else

`define TSMS_ASSERT(lbl, cond)
`define TSMS_ASSERT_IMP(lbl, ante, cons)
`define TSMS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[sv/tsms_pkg.sv]
// Shared types and constants for the traffic signal mode sequencer.
// No dependencies.
package tsms_pkg;

	// Default width of the tick counter
	localparam int COUNT_BITS_DEF = 16;

	// Configuration register file
	localparam int REG_W    = 16;
	localparam int REG_IX_W = 2;
	localparam logic [REG_IX_W-1:0] REG_INTRO_TICKS = 2'd0;
	localparam logic [REG_IX_W-1:0] REG_PHASE_TICKS = 2'd1;
	localparam logic [REG_W-1:0] INTRO_TICKS_RST = 16'd1000;
	localparam logic [REG_W-1:0] PHASE_TICKS_RST = 16'd4001;

	// Item commands
	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_KEY     = 2'd1,
		CMD_DENSITY = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	// Run modes
	typedef enum logic [1:0] {
		MODE_SELECT  = 2'd0,
		MODE_AUTO    = 2'd1,
		MODE_NORMAL  = 2'd2,
		MODE_DENSITY = 2'd3
	} mode_t;

	// Keypad codes in mode select
	localparam logic [3:0] KEY_SEL_AUTO    = 4'd1;
	localparam logic [3:0] KEY_SEL_NORMAL  = 4'd2;
	localparam logic [3:0] KEY_SEL_DENSITY = 4'd4;
	// Keypad codes in normal mode
	localparam logic [3:0] KEY_RUN_EW      = 4'd1;
	localparam logic [3:0] KEY_RUN_NS      = 4'd2;
	localparam logic [3:0] KEY_RUN_BACK    = 4'd8;

	// Phase indexes that open a signal pair, and the last phase index
	localparam logic [1:0] PH_EW_PAIR = 2'd0;
	localparam logic [1:0] PH_NS_PAIR = 2'd2;
	localparam logic [1:0] PH_LAST    = 2'd3;

	// Messages
	localparam logic [3:0] MSG_SIGNAL_BASE = 4'd4;
	localparam logic [3:0] MSG_IDLE        = 4'd8;

endpackage

[sv/traffic_signal_mode_sequencer_core.sv]
// Top level of the traffic signal mode sequencer: word register, state update, result register.
// Depends on tsms_pkg and traffic_signal_mode_sequencer_core_macros.svh.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------------
//  in      | in_valid / in_ready   | command, key_value, density_ew, density_ns
//  out     | out_valid / out_ready | message, mode, wants_key, wants_density
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (cfg_ready always high)
//
// One word per cycle sustained while out_ready stays high; a result passes through the input register,
// then the state update into the result register, where it waits for out_ready.
// in_ready falls only while both the input register and the result register hold
// a word and out_ready is low.
// Asynchronous reset starts the intro sequence with intro_ticks 1000, phase_ticks 4001.
`include "traffic_signal_mode_sequencer_core_macros.svh"

module traffic_signal_mode_sequencer_core #(
	parameter int COUNT_BITS = tsms_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  command,
	input  logic [3:0]                  key_value,
	input  logic [9:0]                  density_ew,
	input  logic [9:0]                  density_ns,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [3:0]                  message,
	output logic [1:0]                  mode,
	output logic                        wants_key,
	output logic                        wants_density,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tsms_pkg::REG_IX_W-1:0] cfg_index,
	input  logic [tsms_pkg::REG_W-1:0]    cfg_data
);

	// Compare width covers both the counter plus one and the longest intro length
	localparam int CMP_W = (COUNT_BITS + 1 > tsms_pkg::REG_W + 1) ?
		COUNT_BITS + 1 : tsms_pkg::REG_W + 1;
	localparam logic [CMP_W-1:0] CNT_CAP = CMP_W'({1'b1, {COUNT_BITS{1'b0}}});

	// Input register
	logic                 valid_s1;
	tsms_pkg::cmd_t       cmd_s1;
	logic [3:0]           key_s1;
	logic [9:0]           ew_s1;
	logic [9:0]           ns_s1;

	// Result register
	logic                 out_valid_s2;
	logic [3:0]           message_s2;
	logic [1:0]           mode_s2;
	logic                 wants_key_s2;
	logic                 wants_density_s2;

	// Configuration and sequencer state
	logic [tsms_pkg::REG_W-1:0] intro_ticks_q;
	logic [tsms_pkg::REG_W-1:0] phase_ticks_q;
	tsms_pkg::mode_t      run_mode_q, run_mode_d;
	logic [1:0]           phase_idx_q, phase_idx_d;
	logic [COUNT_BITS-1:0] tick_cnt_q, tick_cnt_d;
	logic                 intro_done_q, intro_done_d;
	logic                 active_q, active_d;

	logic                 advance;
	logic                 step;
	logic [tsms_pkg::REG_W:0] base_len;
	logic [CMP_W-1:0]     limit;
	logic [CMP_W-1:0]     cnt_next;

	logic [3:0]           message_d;
	logic                 wants_key_d;
	logic                 wants_density_d;

	// Handshake: result stage drains or is empty, input stage follows
	assign advance   = !out_valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign step      = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	// Capture incoming word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= tsms_pkg::cmd_t'(command);
			key_s1 <= key_value;
			ew_s1  <= density_ew;
			ns_s1  <= density_ns;
		end
	end

	// Configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intro_ticks_q <= tsms_pkg::INTRO_TICKS_RST;
			phase_ticks_q <= tsms_pkg::PHASE_TICKS_RST;
		end else if (cfg_valid) begin
			if (cfg_index == tsms_pkg::REG_INTRO_TICKS) begin
				intro_ticks_q <= cfg_data;
			end else if (cfg_index == tsms_pkg::REG_PHASE_TICKS) begin
				phase_ticks_q <= cfg_data;
			end
		end
	end

	// Length of the running message, at least one tick, at most the counter range
	always_comb begin
		if (intro_done_q) begin
			base_len = {1'b0, phase_ticks_q};
		end else if (phase_idx_q == 2'd0) begin
			base_len = {1'b0, intro_ticks_q} + 17'd1;
		end else begin
			base_len = {1'b0, intro_ticks_q};
		end
		limit = CMP_W'(base_len);
		if (limit == '0) begin
			limit = CMP_W'(1);
		end else if (limit > CNT_CAP) begin
			limit = CNT_CAP;
		end
		cnt_next = CMP_W'(tick_cnt_q) + CMP_W'(1);
	end

	// Next state
	always_comb begin
		run_mode_d   = run_mode_q;
		phase_idx_d  = phase_idx_q;
		tick_cnt_d   = tick_cnt_q;
		intro_done_d = intro_done_q;
		active_d     = active_q;
		if (step) begin
			unique case (cmd_s1)
				tsms_pkg::CMD_TICK: begin
					if (active_q) begin
						if (cnt_next < limit) begin
							tick_cnt_d = cnt_next[COUNT_BITS-1:0];
						end else begin
							tick_cnt_d = '0;
							if (!intro_done_q) begin
								if (phase_idx_q == tsms_pkg::PH_LAST) begin
									intro_done_d = 1'b1;
									active_d     = 1'b0;
									phase_idx_d  = 2'd0;
								end else begin
									phase_idx_d = phase_idx_q + 2'd1;
								end
							end else if (run_mode_q == tsms_pkg::MODE_AUTO) begin
								phase_idx_d = phase_idx_q + 2'd1;
							end else if (!phase_idx_q[0]) begin
								phase_idx_d = phase_idx_q + 2'd1;
							end else begin
								active_d    = 1'b0;
								phase_idx_d = 2'd0;
							end
						end
					end
				end
				tsms_pkg::CMD_KEY: begin
					if (!active_q) begin
						unique case (run_mode_q)
							tsms_pkg::MODE_SELECT: begin
								unique case (key_s1)
									tsms_pkg::KEY_SEL_AUTO: begin
										run_mode_d  = tsms_pkg::MODE_AUTO;
										phase_idx_d = tsms_pkg::PH_EW_PAIR;
										tick_cnt_d  = '0;
										active_d    = 1'b1;
									end
									tsms_pkg::KEY_SEL_NORMAL:  run_mode_d = tsms_pkg::MODE_NORMAL;
									tsms_pkg::KEY_SEL_DENSITY: run_mode_d = tsms_pkg::MODE_DENSITY;
									default: ;
								endcase
							end
							tsms_pkg::MODE_NORMAL: begin
								unique case (key_s1)
									tsms_pkg::KEY_RUN_EW: begin
										phase_idx_d = tsms_pkg::PH_EW_PAIR;
										tick_cnt_d  = '0;
										active_d    = 1'b1;
									end
									tsms_pkg::KEY_RUN_NS: begin
										phase_idx_d = tsms_pkg::PH_NS_PAIR;
										tick_cnt_d  = '0;
										active_d    = 1'b1;
									end
									tsms_pkg::KEY_RUN_BACK: run_mode_d = tsms_pkg::MODE_SELECT;
									default: ;
								endcase
							end
							default: ;
						endcase
					end
				end
				tsms_pkg::CMD_DENSITY: begin
					if (!active_q && run_mode_q == tsms_pkg::MODE_DENSITY) begin
						phase_idx_d = (ew_s1 >= ns_s1) ? tsms_pkg::PH_EW_PAIR :
							tsms_pkg::PH_NS_PAIR;
						tick_cnt_d  = '0;
						active_d    = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Result fields from the state after the word
	always_comb begin
		if (!active_d) begin
			message_d = tsms_pkg::MSG_IDLE;
		end else if (!intro_done_d) begin
			message_d = {2'b00, phase_idx_d};
		end else begin
			message_d = tsms_pkg::MSG_SIGNAL_BASE + {2'b00, phase_idx_d};
		end
		wants_key_d     = !active_d && (run_mode_d == tsms_pkg::MODE_SELECT ||
			run_mode_d == tsms_pkg::MODE_NORMAL);
		wants_density_d = !active_d && run_mode_d == tsms_pkg::MODE_DENSITY;
	end

	// Hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_mode_q   <= tsms_pkg::MODE_SELECT;
			phase_idx_q  <= 2'd0;
			tick_cnt_q   <= '0;
			intro_done_q <= 1'b0;
			active_q     <= 1'b1;
		end else begin
			run_mode_q   <= run_mode_d;
			phase_idx_q  <= phase_idx_d;
			tick_cnt_q   <= tick_cnt_d;
			intro_done_q <= intro_done_d;
			active_q     <= active_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			message_s2       <= message_d;
			mode_s2          <= run_mode_d;
			wants_key_s2     <= wants_key_d;
			wants_density_s2 <= wants_density_d;
		end
	end

	assign out_valid     = out_valid_s2;
	assign message       = message_s2;
	assign mode          = mode_s2;
	assign wants_key     = wants_key_s2;
	assign wants_density = wants_density_s2;

	// Checks
	`TSMS_ASSERT(a_wants_exclusive, !(wants_key_d && wants_density_d))
	`TSMS_ASSERT_IMP(a_idle_count_clear, !active_q, tick_cnt_q == '0)
	`TSMS_ASSERT_IMP(a_intro_in_select, !intro_done_q, run_mode_q == tsms_pkg::MODE_SELECT)
	`TSMS_ASSERT_IMP(a_stall_cause, !in_ready, valid_s1 && out_valid_s2 && !out_ready)
	`TSMS_ASSERT_NXT(a_step_fills_result, step, out_valid_s2)

endmodule
